// File: hdl/gckf_pkg.sv
// ----------------------------------------------------------------------------
// Grid cell height fusion package
// Shared payload types, controller states, command and status groups.
// ----------------------------------------------------------------------------
package gckf_pkg;

  // Payload field types.
  typedef logic [5:0]         cell_idx_t;
  typedef logic signed [31:0] height_t;
  typedef logic [31:0]        variance_t;

  // Reset value of the initial variance register (100.0 in Q16.16).
  localparam variance_t INIT_VAR_RESET = 32'd6553600;

  // The gain divider produces one quotient bit per step, bits 16 down to 0.
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = 5;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_MULM,
    ST_MULV,
    ST_WB
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic latch_in;
    logic load_op;
    logic div_step;
    logic mul_m;
    logic mul_v;
    logic wb;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } ctrl_sts_t;

endpackage

// File: hdl/gckf_if.sv
// ----------------------------------------------------------------------------
// Grid cell height fusion channels
// Valid/ready channels for measurement requests and fused cell results.
// ----------------------------------------------------------------------------
interface gckf_in_if;
  import gckf_pkg::*;

  logic      valid;
  logic      ready;
  cell_idx_t cell_row;
  cell_idx_t cell_col;
  height_t   measured_height;
  variance_t measured_variance;

  modport source (output valid, output cell_row, output cell_col,
                  output measured_height, output measured_variance, input ready);
  modport sink   (input valid, input cell_row, input cell_col,
                  input measured_height, input measured_variance, output ready);
endinterface

interface gckf_out_if;
  import gckf_pkg::*;

  logic      valid;
  logic      ready;
  cell_idx_t out_row;
  cell_idx_t out_col;
  height_t   fused_height;
  variance_t fused_variance;
  logic      status;

  modport source (output valid, output out_row, output out_col, output fused_height,
                  output fused_variance, output status, input ready);
  modport sink   (input valid, input out_row, input out_col, input fused_height,
                  input fused_variance, input status, output ready);
endinterface

// File: hdl/gckf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gckf_ram #(
  parameter  int WIDTH = 65,
  parameter  int DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/gckf_ctrl.sv
// ----------------------------------------------------------------------------
// Grid cell height fusion controller
// Sequences the clearing pass, cell read, gain divide, multiplies and write-back.
// ----------------------------------------------------------------------------
module gckf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gckf_pkg::ctrl_sts_t sts,
  output gckf_pkg::ctrl_cmd_t cmd
);
  import gckf_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // State and divide step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_op = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MULM;
        end
      end
      ST_MULM: begin
        cmd.mul_m = 1'b1;
        state_nxt = ST_MULV;
      end
      ST_MULV: begin
        cmd.mul_v = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // Hold the update until the result register can take it.
        if (!sts.out_stall) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An accepted request always starts with the cell read.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_READ))
    else $error("accepted request did not start a cell read");

  // Write-back never overwrites a result that is still waiting.
  a_wb_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !sts.out_stall)
    else $error("write-back while the result register is stalled");

  // The divider runs exactly its number of steps.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("divide step counter out of range");

endmodule

// File: hdl/gckf_dpath.sv
// ----------------------------------------------------------------------------
// Grid cell height fusion datapath
// Cell memory, gain divider, two multiplies, saturation and result register.
// ----------------------------------------------------------------------------
module gckf_dpath #(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gckf_pkg::ctrl_cmd_t   cmd,
  output gckf_pkg::ctrl_sts_t   sts,
  input  gckf_pkg::variance_t   init_var,
  input  gckf_pkg::cell_idx_t   in_row,
  input  gckf_pkg::cell_idx_t   in_col,
  input  gckf_pkg::height_t     in_height,
  input  gckf_pkg::variance_t   in_variance,
  gckf_out_if.source            out_ch
);
  import gckf_pkg::*;

  localparam int CELLS = MAP_ROWS * MAP_COLS;
  localparam int AW    = $clog2(CELLS);
  // Memory word: written flag, variance, mean.
  localparam int MW    = 65;

  // Latched request.
  cell_idx_t row_r, col_r;
  height_t   z_r;
  variance_t pm_r;
  logic [AW-1:0] idx;

  // Operands and divider.
  logic [31:0]        m_r;
  variance_t          pg_r;
  logic [32:0]        sum_r;
  logic signed [32:0] diff_r;
  logic               zero_r;
  logic [33:0]        rem_r;
  logic [16:0]        q_r;
  logic [15:0]        gain;

  // Products.
  logic signed [49:0] prod_m_r;
  logic [48:0]        prod_v_r;

  // Memory ports.
  logic [AW-1:0] clr_cnt_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [MW-1:0] ram_rdata;

  // Load and update values.
  logic               hit;
  logic [31:0]        m_ld;
  variance_t          pg_ld;
  logic [32:0]        sum_ld;
  logic signed [32:0] diff_ld;
  logic [33:0]        rem_sub;
  logic               rem_ge;
  logic signed [49:0] sh_m;
  logic signed [34:0] m_ext, nm_wide;
  logic [31:0]        nm;
  variance_t          nv;

  // Result register.
  logic      out_valid_r;
  cell_idx_t out_row_r, out_col_r;
  logic [31:0] out_height_r;
  variance_t out_var_r;
  logic      out_status_r;

  // Latch the request with row and column clamped to the map.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      row_r <= (int'(in_row) >= MAP_ROWS) ? 6'(MAP_ROWS - 1) : in_row;
      col_r <= (int'(in_col) >= MAP_COLS) ? 6'(MAP_COLS - 1) : in_col;
      z_r   <= in_height;
      pm_r  <= in_variance;
    end
  end

  assign idx = AW'(int'(row_r) * MAP_COLS + int'(col_r));

  // Clearing pass address after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == AW'(CELLS - 1));

  // Cell memory: the clearing pass writes zero words, write-back writes the update.
  assign ram_we    = cmd.clear | cmd.wb;
  assign ram_waddr = cmd.clear ? clr_cnt_r : idx;
  assign ram_wdata = cmd.clear ? '0 : {1'b1, nv, nm};

  gckf_ram #(
    .WIDTH (MW),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // A cell never written reads as mean zero and the configured variance.
  assign hit     = ram_rdata[64];
  assign m_ld    = hit ? ram_rdata[31:0] : '0;
  assign pg_ld   = hit ? ram_rdata[63:32] : init_var;
  assign sum_ld  = {1'b0, pg_ld} + {1'b0, pm_r};
  assign diff_ld = $signed({z_r[31], z_r}) - $signed({m_ld[31], m_ld});

  // One restoring divide step of Pg * 2^16 / (Pg + Pm).
  assign rem_ge  = (rem_r >= {1'b0, sum_r});
  assign rem_sub = rem_ge ? (rem_r - {1'b0, sum_r}) : rem_r;

  // A quotient of exactly one saturates; a zero sum forces the gain to zero.
  assign gain = zero_r ? 16'd0 : (q_r[16] ? 16'hFFFF : q_r[15:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      m_r    <= m_ld;
      pg_r   <= pg_ld;
      sum_r  <= sum_ld;
      diff_r <= diff_ld;
      zero_r <= (sum_ld == '0);
      rem_r  <= {2'b00, pg_ld};
      q_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[32:0], 1'b0};
      q_r   <= {q_r[15:0], rem_ge};
    end
  end

  // Mean correction product, then variance product.
  always_ff @(posedge clk) begin
    if (cmd.mul_m) begin
      prod_m_r <= $signed({1'b0, gain}) * diff_r;
    end
    if (cmd.mul_v) begin
      prod_v_r <= (17'h10000 - {1'b0, gain}) * pg_r;
    end
  end

  // Floor the correction, add it to the mean and saturate.
  assign sh_m    = prod_m_r >>> 16;
  assign m_ext   = {{3{m_r[31]}}, m_r};
  assign nm_wide = m_ext + sh_m[34:0];

  always_comb begin
    if (nm_wide[34:31] == 4'b0000 || nm_wide[34:31] == 4'b1111) begin
      nm = nm_wide[31:0];
    end else if (nm_wide[34]) begin
      nm = 32'h8000_0000;
    end else begin
      nm = 32'h7FFF_FFFF;
    end
  end

  assign nv = prod_v_r[47:16];

  // Result register parts the update from a stalled receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_row_r    <= row_r;
      out_col_r    <= col_r;
      out_height_r <= nm;
      out_var_r    <= nv;
      out_status_r <= zero_r;
    end
  end

  assign sts.out_stall       = out_valid_r & ~out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_row        = out_row_r;
  assign out_ch.out_col        = out_col_r;
  assign out_ch.fused_height   = height_t'(out_height_r);
  assign out_ch.fused_variance = out_var_r;
  assign out_ch.status         = out_status_r;

endmodule

// File: hdl/grid_cell_kalman_height_fusion_unit.sv
// ----------------------------------------------------------------------------
// Grid cell Kalman height fusion unit
// Fuses height measurements into a per-cell mean and variance map.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one measurement request per handshake: cell row and column,
//   a signed Q16.16 height and an unsigned Q16.16 variance. out_ch returns one
//   result per request with the updated mean, variance and a status flag that
//   is set when both variances were zero.
//   cfg_we/cfg_wdata write the variance used for cells never written; write it
//   only while the unit is idle.
//   A request passes through the cell memory read, the operand load, the
//   17-step radix-2 divider that forms the gain, two multiplies and the
//   write-back; a new request is taken only after the previous one has
//   been written back.
//   After reset the unit clears the cell memory, one cell per cycle, through
//   all MAP_ROWS * MAP_COLS cells (4096 by default) with in_ch.ready low.
//   If the receiver stalls, the result waits in the output register; the next
//   request is still accepted and processed, and its write-back waits until
//   the output register is free.
// ----------------------------------------------------------------------------
module grid_cell_kalman_height_fusion_unit #(
  parameter int MAP_ROWS = 64,
  parameter int MAP_COLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  gckf_pkg::variance_t cfg_wdata,
  gckf_in_if.sink             in_ch,
  gckf_out_if.source          out_ch
);
  import gckf_pkg::*;

  variance_t init_var_r;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // Initial variance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_var_r <= INIT_VAR_RESET;
    end else if (cfg_we) begin
      init_var_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = in_ready;

  gckf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gckf_dpath #(
    .MAP_ROWS (MAP_ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .init_var    (init_var_r),
    .in_row      (in_ch.cell_row),
    .in_col      (in_ch.cell_col),
    .in_height   (in_ch.measured_height),
    .in_variance (in_ch.measured_variance),
    .out_ch      (out_ch)
  );

endmodule

// File: tb/grid_cell_kalman_height_fusion_unit_test.sv
// ----------------------------------------------------------------------------
// Grid cell Kalman height fusion unit testbench
// Sends measurement requests through the input channel, predicts each fused
// cell mean and variance with a local model of the map, and checks every
// result in order across several initial-variance settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_cell_kalman_height_fusion_unit_test;
  import gckf_pkg::*;

  // One measurement request and one fused cell result.
  typedef struct {
    cell_idx_t row;
    cell_idx_t col;
    height_t   height;
    variance_t variance;
  } meas_t;

  typedef struct {
    cell_idx_t row;
    cell_idx_t col;
    height_t   height;
    variance_t variance;
    logic      status;
  } fused_t;

  // Handshake idle patterns used by the random phases.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int CELLS        = 4096;
  localparam int QUIET_LIMIT  = 20000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 69;
  localparam int SETTLE_TICKS = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  variance_t cfg_wdata;

  gckf_in_if  meas_bus ();
  gckf_out_if fused_bus ();

  grid_cell_kalman_height_fusion_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (meas_bus),
    .out_ch    (fused_bus)
  );

  always #1 clk = ~clk;

  // Local copy of the cell map and of the initial variance register.
  height_t   map_mean [CELLS];
  variance_t map_var [CELLS];
  bit        map_known [CELLS];
  variance_t init_variance = INIT_VAR_RESET;

  meas_t  meas_queue[$];
  fused_t fused_expect_q[$];
  meas_t  meas_hold;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // Scalar Kalman update of one cell; updates the local map and returns the
  // result that the unit must produce for this request.
  function automatic fused_t fuse_cell(meas_t req);
    fused_t      res;
    logic [11:0] slot;
    height_t     old_mean;
    variance_t   old_var;
    logic [32:0] var_sum;
    logic [63:0] quot;
    logic [15:0] gain;
    longint      delta;
    longint      new_mean;
    logic [63:0] var_prod;
    slot = {req.row, req.col};
    if (map_known[slot]) begin
      old_mean = map_mean[slot];
      old_var  = map_var[slot];
    end else begin
      old_mean = '0;
      old_var  = init_variance;
    end
    // The gain is Pg/(Pg+Pm) in Q0.16; a gain of one is held just below one.
    var_sum = {1'b0, old_var} + {1'b0, req.variance};
    res.status = (var_sum == '0);
    if (res.status) begin
      gain = '0;
    end else begin
      quot = {16'b0, old_var, 16'b0} / {31'b0, var_sum};
      gain = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    end
    // Mean step is floored after dropping 16 fraction bits, then saturated.
    delta = longint'(req.height) - longint'(old_mean);
    new_mean = longint'(old_mean) + ((delta * longint'(gain)) >>> 16);
    if (new_mean > longint'(2147483647)) begin
      new_mean = longint'(2147483647);
    end else if (new_mean < -longint'(2147483647) - 1) begin
      new_mean = -longint'(2147483647) - 1;
    end
    var_prod = (64'd65536 - 64'(gain)) * 64'(old_var);
    res.row      = req.row;
    res.col      = req.col;
    res.height   = new_mean[31:0];
    res.variance = var_prod[47:16];
    map_mean[slot]  = res.height;
    map_var[slot]   = res.variance;
    map_known[slot] = 1'b1;
    return res;
  endfunction

  task automatic count_failure(string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic queue_meas(cell_idx_t row, cell_idx_t col, height_t height,
                            variance_t variance);
    meas_t req;
    req.row      = row;
    req.col      = col;
    req.height   = height;
    req.variance = variance;
    meas_queue = {meas_queue, req};
  endtask

  // Waits on the falling edge until every request is sent and answered.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (meas_queue.size() != 0 || meas_bus.valid !== 1'b0 ||
               fused_expect_q.size() != 0);
  endtask

  // Request driver: a request stays on the bus until it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      meas_bus.valid             <= 1'b0;
      meas_bus.cell_row          <= '0;
      meas_bus.cell_col          <= '0;
      meas_bus.measured_height   <= '0;
      meas_bus.measured_variance <= '0;
    end else begin
      if (meas_bus.valid && meas_bus.ready) begin
        fused_expect_q = {fused_expect_q, fuse_cell(meas_hold)};
      end
      if (!meas_bus.valid || meas_bus.ready) begin
        if (meas_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          meas_hold = meas_queue.pop_front();
          meas_bus.valid             <= 1'b1;
          meas_bus.cell_row          <= meas_hold.row;
          meas_bus.cell_col          <= meas_hold.col;
          meas_bus.measured_height   <= meas_hold.height;
          meas_bus.measured_variance <= meas_hold.variance;
        end else begin
          meas_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each fused result with the oldest prediction.
  always @(posedge clk) begin
    fused_t got;
    fused_t want;
    if (!rst_n) begin
      fused_bus.ready <= 1'b0;
    end else begin
      if (fused_bus.valid && fused_bus.ready) begin
        got.row      = fused_bus.out_row;
        got.col      = fused_bus.out_col;
        got.height   = fused_bus.fused_height;
        got.variance = fused_bus.fused_variance;
        got.status   = fused_bus.status;
        if (fused_expect_q.size() == 0) begin
          count_failure($sformatf("unexpected result: row %0d col %0d h %h v %h st %b",
                                  got.row, got.col, got.height, got.variance,
                                  got.status));
        end else begin
          want = fused_expect_q.pop_front();
          if (got.row !== want.row || got.col !== want.col ||
              got.height !== want.height || got.variance !== want.variance ||
              got.status !== want.status) begin
            count_failure($sformatf(
              "mismatch: exp row %0d col %0d h %h v %h st %b, got row %0d col %0d h %h v %h st %b",
              want.row, want.col, want.height, want.variance, want.status,
              got.row, got.col, got.height, got.variance, got.status));
          end
        end
      end
      fused_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (meas_bus.valid && meas_bus.ready) ||
        (fused_bus.valid && fused_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, a directed phase, then random phases per setting.
  initial begin
    variance_t  cfg_plan [PHASES];
    idle_mode_t mode;
    meas_t      req;
    int         p;
    int         i;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    cfg_plan = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, 32'h0001_0000,
                 32'h8000_0000, $urandom, INIT_VAR_RESET};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests with the register at its reset value.
    // Exact measurement on a fresh cell: the gain saturates just below one.
    queue_meas(6'd0, 6'd0, 32'sh7FFF_FFFF, 32'd0);
    queue_meas(6'd0, 6'd0, 32'sh8000_0000, 32'hFFFF_FFFF);
    queue_meas(6'd0, 6'd1, -32'sd1, 32'd6553600);
    queue_meas(6'd63, 6'd63, 32'sh8000_0000, 32'd0);
    queue_meas(6'd63, 6'd63, 32'sh7FFF_FFFF, 32'd0);
    // Repeated exact measurements drive the cell variance to zero, after
    // which both variances are zero and the status flag must rise.
    queue_meas(6'd63, 6'd0, 32'sd12345, 32'd0);
    queue_meas(6'd63, 6'd0, 32'sd12345, 32'd0);
    queue_meas(6'd63, 6'd0, 32'sd12345, 32'd0);
    queue_meas(6'd63, 6'd0, -32'sd777, 32'd5);
    queue_meas(6'd0, 6'd63, 32'sd0, 32'd1);
    queue_meas(6'd32, 6'd16, 32'sh1234_5678, 32'h8000_0000);
    queue_meas(6'd21, 6'd42, 32'shDEAD_BEEF, 32'h5555_5555);
    queue_meas(6'd42, 6'd21, 32'sh5555_5555, 32'hAAAA_AAAA);
    queue_meas(6'd0, 6'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    queue_meas(6'd42, 6'd21, 32'shAAAA_AAAA, 32'd0);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      // Register write while the unit is idle.
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= cfg_plan[p];
      init_variance = cfg_plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);

      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase

      // Most requests hit a small group of cells so that updates stack up;
      // the rest land anywhere on the map.
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 70) begin
          req.row = 6'($urandom_range(3));
          req.col = 6'($urandom_range(3));
        end else begin
          req.row = 6'($urandom_range(63));
          req.col = 6'($urandom_range(63));
        end
        case ($urandom_range(5))
          0, 1: req.height = $urandom;
          2: req.height = $urandom_range(2097152) - 1048576;
          3: req.height = 32'sh7FFF_FFFF;
          4: req.height = 32'sh8000_0000;
          default: req.height = $urandom_range(255);
        endcase
        case ($urandom_range(5))
          0: req.variance = 32'd0;
          1: req.variance = 32'hFFFF_FFFF;
          2: req.variance = $urandom;
          3: req.variance = $urandom_range(255);
          default: req.variance = $urandom_range(32'h00FF_FFFF);
        endcase
        meas_queue = {meas_queue, req};
      end
      wait_idle();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (fused_expect_q.size() != 0) begin
      count_failure($sformatf("%0d results never arrived", fused_expect_q.size()));
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
